// ===== rtl/lfu_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package lfu_pkg;

    // Fixed field widths
    localparam int CFG_W   = 6;
    localparam int CNT_W   = 16;
    localparam int STAMP_W = 32;

    localparam logic [CFG_W-1:0]   CFG_RESET = 6'd20;
    localparam logic [CNT_W-1:0]   CNT_MAX   = 16'hFFFF;
    localparam logic [CNT_W-1:0]   CNT_ONE   = 16'd1;
    localparam logic [STAMP_W-1:0] STAMP_MAX = 32'hFFFF_FFFF;

    // Flags carried by the scan token from cell to cell
    typedef struct packed {
        logic vld;   // token present
        logic hit;   // key found in an earlier cell
        logic empt;  // empty slot found in an earlier cell
        logic best;  // victim candidate recorded
    } tok_flags_t;

    // Broadcast write into the cell row
    typedef struct packed {
        logic en;    // write the selected cell's count
        logic fill;  // also load key and stamp
    } wr_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/lfu_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lfu_cell #(
    parameter int IDX      = 0,
    parameter int KEY_BITS = 8,
    parameter int IDX_W    = 5
) (
    input  wire                               aclk,
    input  wire                               aresetn,
    input  wire                               active,
    // token in from the left neighbor
    input  wire lfu_pkg::tok_flags_t          in_flg,
    input  wire [KEY_BITS-1:0]                in_key,
    input  wire [IDX_W-1:0]                   in_sel,
    input  wire [lfu_pkg::CNT_W-1:0]          in_hcnt,
    input  wire [IDX_W-1:0]                   in_bidx,
    input  wire [lfu_pkg::CNT_W-1:0]          in_bcnt,
    input  wire [lfu_pkg::STAMP_W-1:0]        in_bstm,
    input  wire [KEY_BITS-1:0]                in_bkey,
    // token out to the right neighbor
    output lfu_pkg::tok_flags_t               out_flg,
    output logic [KEY_BITS-1:0]               out_key,
    output logic [IDX_W-1:0]                  out_sel,
    output logic [lfu_pkg::CNT_W-1:0]         out_hcnt,
    output logic [IDX_W-1:0]                  out_bidx,
    output logic [lfu_pkg::CNT_W-1:0]         out_bcnt,
    output logic [lfu_pkg::STAMP_W-1:0]       out_bstm,
    output logic [KEY_BITS-1:0]               out_bkey,
    // broadcast write
    input  wire lfu_pkg::wr_ctl_t             wr_ctl,
    input  wire [IDX_W-1:0]                   wr_idx,
    input  wire [KEY_BITS-1:0]                wr_key,
    input  wire [lfu_pkg::CNT_W-1:0]          wr_cnt,
    input  wire [lfu_pkg::STAMP_W-1:0]        wr_stm
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

    // slot contents
    logic [KEY_BITS-1:0]         key_reg;
    logic [lfu_pkg::CNT_W-1:0]   cnt_reg;
    logic [lfu_pkg::STAMP_W-1:0] stm_reg;

    // token registers
    lfu_pkg::tok_flags_t         flg_reg, flg_next;
    logic [KEY_BITS-1:0]         key_t_reg;
    logic [IDX_W-1:0]            sel_reg, sel_next;
    logic [lfu_pkg::CNT_W-1:0]   hcnt_reg, hcnt_next;
    logic [IDX_W-1:0]            bidx_reg, bidx_next;
    logic [lfu_pkg::CNT_W-1:0]   bcnt_reg, bcnt_next;
    logic [lfu_pkg::STAMP_W-1:0] bstm_reg, bstm_next;
    logic [KEY_BITS-1:0]         bkey_reg, bkey_next;

    logic occupied, own_hit, own_empty, better;

    assign occupied  = (key_reg != '0);
    assign own_hit   = active && occupied && (key_reg == in_key);
    assign own_empty = active && !occupied;
    // strict compare keeps the lower slot on a full tie
    assign better    = !in_flg.best || (cnt_reg < in_bcnt) ||
                       ((cnt_reg == in_bcnt) && (stm_reg < in_bstm));

    // merge this slot into the passing token
    always_comb begin
        flg_next  = in_flg;
        sel_next  = in_sel;
        hcnt_next = in_hcnt;
        bidx_next = in_bidx;
        bcnt_next = in_bcnt;
        bstm_next = in_bstm;
        bkey_next = in_bkey;
        if (in_flg.vld && !in_flg.hit) begin
            if (own_hit) begin
                flg_next.hit = 1'b1;
                sel_next     = MY_IDX;
                hcnt_next    = cnt_reg;
            end else if (own_empty && !in_flg.empt) begin
                flg_next.empt = 1'b1;
                sel_next      = MY_IDX;
            end
            if (active && occupied && better) begin
                flg_next.best = 1'b1;
                bidx_next     = MY_IDX;
                bcnt_next     = cnt_reg;
                bstm_next     = stm_reg;
                bkey_next     = key_reg;
            end
        end
    end

    // token stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flg_reg <= '0;
        end else begin
            flg_reg <= flg_next;
        end
        key_t_reg <= in_key;
        sel_reg   <= sel_next;
        hcnt_reg  <= hcnt_next;
        bidx_reg  <= bidx_next;
        bcnt_reg  <= bcnt_next;
        bstm_reg  <= bstm_next;
        bkey_reg  <= bkey_next;
    end

    // slot update from the broadcast write
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_reg <= '0;
        end else if (wr_ctl.en && wr_ctl.fill && (wr_idx == MY_IDX)) begin
            key_reg <= wr_key;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_ctl.en && (wr_idx == MY_IDX)) begin
            cnt_reg <= wr_cnt;
            if (wr_ctl.fill) begin
                stm_reg <= wr_stm;
            end
        end
    end

    assign out_flg  = flg_reg;
    assign out_key  = key_t_reg;
    assign out_sel  = sel_reg;
    assign out_hcnt = hcnt_reg;
    assign out_bidx = bidx_reg;
    assign out_bcnt = bcnt_reg;
    assign out_bstm = bstm_reg;
    assign out_bkey = bkey_reg;

endmodule

`default_nettype wire

// ===== rtl/lfu_slot_replacement.sv =====
// A nonzero key passes the token register of each cell in turn, then its result is
// registered; a zero key raises m_valid in the cycle after it is accepted. No key is
// taken during a scan; the token walks the row one slot per cycle and the chosen slot
// is written as it leaves. A new beat is taken in the cycle the pending result is taken.
// Reset (synchronous, active low): all slots empty, stamp counter 0, slots_in_use 20.
`timescale 1ns / 1ps
`default_nettype none

module lfu_slot_replacement #(
    parameter int SLOTS    = 32,
    parameter int KEY_BITS = 8
) (
    input  wire                          aclk,
    input  wire                          aresetn,
    // configuration
    input  wire                          cfg_we,
    input  wire [lfu_pkg::CFG_W-1:0]     cfg_wdata,
    // input beats
    input  wire                          s_valid,
    output logic                         s_ready,
    input  wire [KEY_BITS-1:0]           s_candidate_key,
    // result beats
    output logic                         m_valid,
    input  wire                          m_ready,
    output logic [$clog2(SLOTS)-1:0]     m_slot_index,
    output logic                         m_was_hit,
    output logic                         m_evicted_valid,
    output logic [KEY_BITS-1:0]          m_evicted_key,
    output logic [lfu_pkg::CNT_W-1:0]    m_slot_count
);

    localparam int IDX_W = $clog2(SLOTS);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_RESP = 3'b100
    } state_t;

    state_t state_reg, state_next;

    logic [lfu_pkg::CFG_W-1:0]   cfg_reg;
    logic [lfu_pkg::STAMP_W-1:0] ins_reg;

    // token chain, position g feeds cell g
    lfu_pkg::tok_flags_t         t_flg  [SLOTS+1];
    logic [KEY_BITS-1:0]         t_key  [SLOTS+1];
    logic [IDX_W-1:0]            t_sel  [SLOTS+1];
    logic [lfu_pkg::CNT_W-1:0]   t_hcnt [SLOTS+1];
    logic [IDX_W-1:0]            t_bidx [SLOTS+1];
    logic [lfu_pkg::CNT_W-1:0]   t_bcnt [SLOTS+1];
    logic [lfu_pkg::STAMP_W-1:0] t_bstm [SLOTS+1];
    logic [KEY_BITS-1:0]         t_bkey [SLOTS+1];
    logic [SLOTS-1:0]            active;

    lfu_pkg::wr_ctl_t            wr_ctl;
    logic [IDX_W-1:0]            wr_idx;
    logic [lfu_pkg::CNT_W-1:0]   wr_cnt;

    logic accept, key_zero, done;

    // result registers
    logic [IDX_W-1:0]          idx_reg, idx_next;
    logic                      hit_reg, hit_next;
    logic                      evv_reg, evv_next;
    logic [KEY_BITS-1:0]       evk_reg, evk_next;
    logic [lfu_pkg::CNT_W-1:0] cnt_reg, cnt_next;

    assign accept   = s_valid && s_ready;
    assign key_zero = (s_candidate_key == '0);
    assign done     = t_flg[SLOTS].vld;

    // configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= lfu_pkg::CFG_RESET;
        end else if (cfg_we) begin
            cfg_reg <= cfg_wdata;
        end
    end

    // token injection at the head of the row
    assign t_flg[0]  = lfu_pkg::tok_flags_t'{vld: accept && !key_zero, hit: 1'b0,
                                             empt: 1'b0, best: 1'b0};
    assign t_key[0]  = s_candidate_key;
    assign t_sel[0]  = '0;
    assign t_hcnt[0] = '0;
    assign t_bidx[0] = '0;
    assign t_bcnt[0] = '0;
    assign t_bstm[0] = '0;
    assign t_bkey[0] = '0;

    // cell row; slot 0 always takes part, a register above SLOTS clamps naturally
    for (genvar g = 0; g < SLOTS; g++) begin : g_cell
        assign active[g] = (g == 0) || (32'(cfg_reg) > g);

        lfu_cell #(
            .IDX      (g),
            .KEY_BITS (KEY_BITS),
            .IDX_W    (IDX_W)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .active   (active[g]),
            .in_flg   (t_flg[g]),
            .in_key   (t_key[g]),
            .in_sel   (t_sel[g]),
            .in_hcnt  (t_hcnt[g]),
            .in_bidx  (t_bidx[g]),
            .in_bcnt  (t_bcnt[g]),
            .in_bstm  (t_bstm[g]),
            .in_bkey  (t_bkey[g]),
            .out_flg  (t_flg[g+1]),
            .out_key  (t_key[g+1]),
            .out_sel  (t_sel[g+1]),
            .out_hcnt (t_hcnt[g+1]),
            .out_bidx (t_bidx[g+1]),
            .out_bcnt (t_bcnt[g+1]),
            .out_bstm (t_bstm[g+1]),
            .out_bkey (t_bkey[g+1]),
            .wr_ctl   (wr_ctl),
            .wr_idx   (wr_idx),
            .wr_key   (t_key[SLOTS]),
            .wr_cnt   (wr_cnt),
            .wr_stm   (ins_reg)
        );
    end

    // decision when the token leaves the row
    always_comb begin
        wr_ctl      = '0;
        wr_ctl.en   = done;
        wr_ctl.fill = !t_flg[SLOTS].hit;
        if (t_flg[SLOTS].hit) begin
            wr_idx = t_sel[SLOTS];
            wr_cnt = (t_hcnt[SLOTS] == lfu_pkg::CNT_MAX) ? lfu_pkg::CNT_MAX
                                                        : t_hcnt[SLOTS] + lfu_pkg::CNT_ONE;
        end else if (t_flg[SLOTS].empt) begin
            wr_idx = t_sel[SLOTS];
            wr_cnt = lfu_pkg::CNT_ONE;
        end else begin
            wr_idx = t_bidx[SLOTS];
            wr_cnt = lfu_pkg::CNT_ONE;
        end
    end

    // stamp counter, saturating
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ins_reg <= '0;
        end else if (done && wr_ctl.fill && (ins_reg != lfu_pkg::STAMP_MAX)) begin
            ins_reg <= ins_reg + 32'd1;
        end
    end

    // result capture
    always_comb begin
        idx_next = idx_reg;
        hit_next = hit_reg;
        evv_next = evv_reg;
        evk_next = evk_reg;
        cnt_next = cnt_reg;
        if (accept && key_zero) begin
            idx_next = '0;
            hit_next = 1'b0;
            evv_next = 1'b0;
            evk_next = '0;
            cnt_next = '0;
        end else if (done) begin
            idx_next = wr_idx;
            hit_next = t_flg[SLOTS].hit;
            evv_next = !t_flg[SLOTS].hit && !t_flg[SLOTS].empt;
            evk_next = evv_next ? t_bkey[SLOTS] : '0;
            cnt_next = wr_cnt;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg <= idx_next;
        hit_reg <= hit_next;
        evv_reg <= evv_next;
        evk_reg <= evk_next;
        cnt_reg <= cnt_next;
    end

    // control sequence
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = key_zero ? ST_RESP : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (done) begin
                    state_next = ST_RESP;
                end
            end
            ST_RESP: begin
                if (accept) begin
                    state_next = key_zero ? ST_RESP : ST_SCAN;
                end else if (m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE) || ((state_reg == ST_RESP) && m_ready);
    assign m_valid = (state_reg == ST_RESP);

    assign m_slot_index    = idx_reg;
    assign m_was_hit       = hit_reg;
    assign m_evicted_valid = evv_reg;
    assign m_evicted_key   = evk_reg;
    assign m_slot_count    = cnt_reg;

endmodule

`default_nettype wire

// ===== rtl/lfu_chk.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lfu_chk #(
    parameter int KEY_BITS = 8,
    parameter int IDX_W    = 5
) (
    input wire                       aclk,
    input wire                       aresetn,
    input wire                       m_valid,
    input wire                       m_ready,
    input wire [IDX_W-1:0]           m_slot_index,
    input wire                       m_was_hit,
    input wire                       m_evicted_valid,
    input wire [KEY_BITS-1:0]        m_evicted_key,
    input wire [lfu_pkg::CNT_W-1:0]  m_slot_count
);

    // a stalled result beat holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_slot_index) && $stable(m_was_hit)
            && $stable(m_evicted_valid) && $stable(m_evicted_key) && $stable(m_slot_count))
        else $error("result beat changed while stalled");

    // a hit never evicts, and a slot without eviction reports no key
    a_hit_no_evict: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_was_hit |-> !m_evicted_valid)
        else $error("hit reported an eviction");

    a_evict_key: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_evicted_valid |-> m_evicted_key == '0)
        else $error("evicted key without eviction");

    // a fill or replacement starts at count one; zero count only for the null key
    a_fill_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_was_hit && m_slot_count != '0 |-> m_slot_count == lfu_pkg::CNT_ONE)
        else $error("miss result with count other than one");

    a_null_key: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_slot_count == '0 |-> m_slot_index == '0 && !m_was_hit
            && !m_evicted_valid)
        else $error("zero-count result not all zero");

endmodule

bind lfu_slot_replacement lfu_chk #(
    .KEY_BITS (KEY_BITS),
    .IDX_W    ($clog2(SLOTS))
) u_lfu_chk (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_slot_index    (m_slot_index),
    .m_was_hit       (m_was_hit),
    .m_evicted_valid (m_evicted_valid),
    .m_evicted_key   (m_evicted_key),
    .m_slot_count    (m_slot_count)
);

`default_nettype wire

// ===== tb/sv/tb_lfu_slot_replacement.sv =====
`timescale 1ns / 1ps

module tb_lfu_slot_replacement;

    localparam int SLOTS    = 32;
    localparam int KEY_BITS = 8;
    localparam int SLOT_W   = $clog2(SLOTS);
    localparam int PHASES   = 8;
    localparam int PHASE_BEATS = 215;

    // One lookup result as the block reports it
    typedef struct packed {
        logic [SLOT_W-1:0]         slot_index;
        logic                      was_hit;
        logic                      evicted_valid;
        logic [KEY_BITS-1:0]       evicted_key;
        logic [lfu_pkg::CNT_W-1:0] slot_count;
    } lookup_t;

    // Directed rows: register write, key checked by the predictor, key with known result
    typedef enum logic [1:0] {
        ROW_CFG,
        ROW_PREDICTED,
        ROW_KNOWN
    } row_kind_t;

    typedef struct packed {
        row_kind_t                 kind;
        logic [lfu_pkg::CFG_W-1:0] cfg_value;
        logic [KEY_BITS-1:0]       key;
        lookup_t                   want;
    } dir_row_t;

    // Idling modes, one per phase
    typedef enum logic [1:0] {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                      cfg_we    = 1'b0;
    logic [lfu_pkg::CFG_W-1:0] cfg_wdata = '0;
    logic                      s_valid   = 1'b0;
    logic                      s_ready;
    logic [KEY_BITS-1:0]       s_candidate_key = '0;
    logic                      m_valid;
    logic                      m_ready   = 1'b0;
    logic [SLOT_W-1:0]         m_slot_index;
    logic                      m_was_hit;
    logic                      m_evicted_valid;
    logic [KEY_BITS-1:0]       m_evicted_key;
    logic [lfu_pkg::CNT_W-1:0] m_slot_count;

    // Predictor state
    logic [KEY_BITS-1:0]         slot_keys_q   [SLOTS] = '{default: '0};
    logic [lfu_pkg::CNT_W-1:0]   slot_counts_q [SLOTS] = '{default: '0};
    logic [lfu_pkg::STAMP_W-1:0] slot_stamps_q [SLOTS] = '{default: '0};
    logic [lfu_pkg::STAMP_W-1:0] fill_stamp   = '0;
    logic [lfu_pkg::CFG_W-1:0]   policy_slots = lfu_pkg::CFG_RESET;

    lookup_t pending_lookups [$];
    int      mismatch_count = 0;
    int      send_idle_pct  = 0;
    int      stall_pct      = 0;

    // Key pool for the random phases
    logic [KEY_BITS-1:0] key_pool [40];
    int                  pool_size = 1;

    dir_row_t directed_rows [0:22];

    always #1 aclk = ~aclk;

    lfu_slot_replacement #(
        .SLOTS    (SLOTS),
        .KEY_BITS (KEY_BITS)
    ) dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_candidate_key (s_candidate_key),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_slot_index    (m_slot_index),
        .m_was_hit       (m_was_hit),
        .m_evicted_valid (m_evicted_valid),
        .m_evicted_key   (m_evicted_key),
        .m_slot_count    (m_slot_count)
    );

    // Register value as the policy sees it: 0 acts as 1, above SLOTS acts as SLOTS
    function automatic int active_slots();
        if (policy_slots == 0) return 1;
        if (policy_slots > SLOTS) return SLOTS;
        return int'(policy_slots);
    endfunction

    // LFU lookup: hit, else first free slot, else lowest count / oldest stamp / lowest slot
    function automatic lookup_t predict_lookup(input logic [KEY_BITS-1:0] key);
        lookup_t r;
        int      n;
        int      i;
        int      slot;
        bit      hit;
        bit      found_free;
        r = '0;
        if (key == '0) return r;
        n = active_slots();
        hit = 1'b0;
        found_free = 1'b0;
        slot = 0;
        for (i = 0; i < n; i++) begin
            if (!hit && slot_keys_q[i] == key) begin
                hit = 1'b1;
                slot = i;
            end
        end
        if (hit) begin
            if (slot_counts_q[slot] != lfu_pkg::CNT_MAX) slot_counts_q[slot]++;
        end else begin
            for (i = 0; i < n; i++) begin
                if (!found_free && slot_keys_q[i] == '0) begin
                    found_free = 1'b1;
                    slot = i;
                end
            end
            if (!found_free) begin
                slot = 0;
                for (i = 1; i < n; i++) begin
                    if (slot_counts_q[i] < slot_counts_q[slot] ||
                        (slot_counts_q[i] == slot_counts_q[slot] &&
                         slot_stamps_q[i] < slot_stamps_q[slot]))
                        slot = i;
                end
                r.evicted_valid = 1'b1;
                r.evicted_key   = slot_keys_q[slot];
            end
            slot_keys_q[slot]   = key;
            slot_counts_q[slot] = lfu_pkg::CNT_ONE;
            slot_stamps_q[slot] = fill_stamp;
            if (fill_stamp != lfu_pkg::STAMP_MAX) fill_stamp++;
        end
        r.slot_index = slot[SLOT_W-1:0];
        r.was_hit    = hit;
        r.slot_count = slot_counts_q[slot];
        return r;
    endfunction

    function automatic dir_row_t cfg_row(input logic [lfu_pkg::CFG_W-1:0] value);
        dir_row_t r;
        r = '0;
        r.kind = ROW_CFG;
        r.cfg_value = value;
        return r;
    endfunction

    function automatic dir_row_t probe_row(input logic [KEY_BITS-1:0] key);
        dir_row_t r;
        r = '0;
        r.kind = ROW_PREDICTED;
        r.key = key;
        return r;
    endfunction

    function automatic dir_row_t known_row(input logic [KEY_BITS-1:0] key, input int slot,
                                           input int hit, input int ev, input int ev_key,
                                           input int cnt);
        dir_row_t r;
        r = '0;
        r.kind = ROW_KNOWN;
        r.key = key;
        r.want.slot_index    = SLOT_W'(slot);
        r.want.was_hit       = 1'(hit);
        r.want.evicted_valid = 1'(ev);
        r.want.evicted_key   = KEY_BITS'(ev_key);
        r.want.slot_count    = lfu_pkg::CNT_W'(cnt);
        return r;
    endfunction

    // Random key: mostly a skewed pool so counts spread, some wide keys, a few zero keys
    function automatic logic [KEY_BITS-1:0] draw_key();
        int roll;
        int a;
        int b;
        roll = $urandom_range(99);
        if (roll < 3) return '0;
        if (roll < 18) return KEY_BITS'($urandom_range(255, 1));
        a = $urandom_range(pool_size - 1);
        b = $urandom_range(pool_size - 1);
        return key_pool[(a < b) ? a : b];
    endfunction

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // Drive one key beat; valid stays up across back-to-back beats
    task automatic send_beat(input logic [KEY_BITS-1:0] key, input bit known,
                             input lookup_t known_want);
        lookup_t predicted;
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < send_idle_pct) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_candidate_key <= key;
        predicted = predict_lookup(key);
        pending_lookups.push_back(known ? known_want : predicted);
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // Register write once the block has drained
    task automatic write_policy(input logic [lfu_pkg::CFG_W-1:0] value);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_lookups.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        policy_slots = value;
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    // Result side: random stalls and scoreboard check
    always @(posedge aclk) begin
        lookup_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (pending_lookups.size() == 0) begin
                    $display("%0t: result beat expected none actual slot %0d key %0d count %0d",
                             $time, m_slot_index, m_evicted_key, m_slot_count);
                    mismatch_count++;
                end else begin
                    want = pending_lookups.pop_front();
                    check_field("slot_index", 16'(want.slot_index), 16'(m_slot_index));
                    check_field("was_hit", 16'(want.was_hit), 16'(m_was_hit));
                    check_field("evicted_valid", 16'(want.evicted_valid),
                                16'(m_evicted_valid));
                    check_field("evicted_key", 16'(want.evicted_key), 16'(m_evicted_key));
                    check_field("slot_count", want.slot_count, m_slot_count);
                end
            end
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Stimulus
    initial begin
        logic [lfu_pkg::CFG_W-1:0] phase_cfg [PHASES-1];
        logic [lfu_pkg::CFG_W-1:0] cfg_value;
        idle_mode_t                mode;
        int                        phase;
        int                        i;

        phase_cfg = '{6'd32, 6'd1, 6'd63, 6'd0, 6'd2, 6'd7, 6'd33};

        // Starts from reset state with 20 slots in use; later rows shrink and grow
        // the register so out-of-range slots keep stale keys
        directed_rows = '{
            known_row(8'd0,   0, 0, 0, 0,   0),
            known_row(8'd1,   0, 0, 0, 0,   1),
            known_row(8'd1,   0, 1, 0, 0,   2),
            known_row(8'd255, 1, 0, 0, 0,   1),
            known_row(8'd128, 2, 0, 0, 0,   1),
            known_row(8'd255, 1, 1, 0, 0,   2),
            known_row(8'd0,   0, 0, 0, 0,   0),
            cfg_row(6'd2),
            known_row(8'd7,   0, 0, 1, 1,   1),   // count tie, older stamp goes
            known_row(8'd128, 0, 0, 1, 7,   1),   // slot 2 not searched
            known_row(8'd255, 1, 1, 0, 0,   3),
            cfg_row(6'd32),
            known_row(8'd128, 0, 1, 0, 0,   2),   // first of two copies wins
            known_row(8'd3,   3, 0, 0, 0,   1),
            cfg_row(6'd0),                        // acts as one slot
            known_row(8'd255, 0, 0, 1, 128, 1),
            known_row(8'd255, 0, 1, 0, 0,   2),
            cfg_row(6'd63),                       // clipped to all slots
            known_row(8'd255, 0, 1, 0, 0,   3),
            probe_row(8'd170),
            probe_row(8'd85),
            probe_row(8'd3),
            probe_row(8'd128)
        };

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[r]) begin
            if (directed_rows[r].kind == ROW_CFG)
                write_policy(directed_rows[r].cfg_value);
            else
                send_beat(directed_rows[r].key, directed_rows[r].kind == ROW_KNOWN,
                          directed_rows[r].want);
        end

        // Random phases, each setting a slot count and an idling mode
        for (phase = 0; phase < PHASES; phase++) begin
            cfg_value = (phase == PHASES - 1) ? lfu_pkg::CFG_W'($urandom_range(31, 1))
                                              : phase_cfg[phase];
            write_policy(cfg_value);
            mode = idle_mode_t'(phase % 4);
            case (mode)
                IDLE_NONE: begin
                    send_idle_pct = 0;
                    stall_pct = 0;
                end
                IDLE_SENDER: begin
                    send_idle_pct = 75;
                    stall_pct = 0;
                end
                IDLE_RECEIVER: begin
                    send_idle_pct = 0;
                    stall_pct = 75;
                end
                default: begin
                    send_idle_pct = 34;
                    stall_pct = 34;
                end
            endcase
            pool_size = active_slots() + $urandom_range(6, 1);
            for (i = 0; i < pool_size; i++) key_pool[i] = KEY_BITS'($urandom_range(255, 1));
            repeat (PHASE_BEATS) send_beat(draw_key(), 1'b0, '0);
        end

        // Drain, then watch for stray beats
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_lookups.size() != 0) @(posedge aclk);
        repeat (SLOTS + 8) @(posedge aclk);

        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Watchdog
    initial begin
        #4_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
